/* design/noek_pkg.sv */
package noek_pkg;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0] RcEncStart = 8'h80;
  localparam logic [7:0] RcDecStart = 8'hD4;
  localparam logic [7:0] RcFwdPoly  = 8'h1B;
  localparam logic [7:0] RcBwdPoly  = 8'h8D;

  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegMode = 3'd4;

  typedef struct packed {
    logic [31:0] data_word0;
    logic [31:0] data_word1;
    logic [31:0] data_word2;
    logic [31:0] data_word3;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_word0;
    logic [31:0] result_word1;
    logic [31:0] result_word2;
    logic [31:0] result_word3;
  } out_word_t;

  // Index 0 is word 0 of the block or key.
  typedef logic [3:0][31:0] blk_t;

  typedef struct packed {
    blk_t key;
    logic decrypt;
  } keyctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic blk_t theta(input blk_t k, input blk_t a_in);
    blk_t a;
    logic [31:0] t;
    a = a_in;
    t = a[0] ^ a[2];
    t = t ^ rotl(t, 8) ^ rotl(t, 24);
    a[1] = a[1] ^ t;
    a[3] = a[3] ^ t;
    a[0] = a[0] ^ k[0];
    a[1] = a[1] ^ k[1];
    a[2] = a[2] ^ k[2];
    a[3] = a[3] ^ k[3];
    t = a[1] ^ a[3];
    t = t ^ rotl(t, 8) ^ rotl(t, 24);
    a[0] = a[0] ^ t;
    a[2] = a[2] ^ t;
    return a;
  endfunction

  function automatic blk_t gamma_step(input blk_t a_in);
    blk_t a;
    logic [31:0] t;
    a = a_in;
    a[1] = a[1] ^ (~a[3] & ~a[2]);
    a[0] = a[0] ^ (a[2] & a[1]);
    t = a[3];
    a[3] = a[0];
    a[0] = t;
    a[2] = a[2] ^ a[0] ^ a[1] ^ a[3];
    a[1] = a[1] ^ (~a[3] & ~a[2]);
    a[0] = a[0] ^ (a[2] & a[1]);
    return a;
  endfunction

  function automatic blk_t round_fn(input blk_t k, input blk_t a_in,
                                    input logic [7:0] rc1, input logic [7:0] rc2);
    blk_t a;
    a = a_in;
    a[0] = a[0] ^ {24'd0, rc1};
    a = theta(k, a);
    a[0] = a[0] ^ {24'd0, rc2};
    a[1] = rotl(a[1], 1);
    a[2] = rotl(a[2], 5);
    a[3] = rotl(a[3], 2);
    a = gamma_step(a);
    a[1] = rotl(a[1], 31);
    a[2] = rotl(a[2], 27);
    a[3] = rotl(a[3], 30);
    return a;
  endfunction

  function automatic blk_t final_fn(input blk_t k, input blk_t a_in,
                                    input logic [7:0] rc1, input logic [7:0] rc2);
    blk_t a;
    a = a_in;
    a[0] = a[0] ^ {24'd0, rc1};
    a = theta(k, a);
    a[0] = a[0] ^ {24'd0, rc2};
    return a;
  endfunction

  function automatic logic [7:0] rc_fwd(input logic [7:0] rc);
    return rc[7] ? ({rc[6:0], 1'b0} ^ RcFwdPoly) : {rc[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] rc_bwd(input logic [7:0] rc);
    return rc[0] ? ({1'b0, rc[7:1]} ^ RcBwdPoly) : {1'b0, rc[7:1]};
  endfunction

  function automatic logic [7:0] rc_enc(input int r);
    logic [7:0] rc;
    rc = RcEncStart;
    for (int i = 0; i < r; i++) begin
      rc = rc_fwd(rc);
    end
    return rc;
  endfunction

  function automatic logic [7:0] rc_dec(input int r);
    logic [7:0] rc;
    rc = RcDecStart;
    for (int i = 0; i < r; i++) begin
      rc = rc_bwd(rc);
    end
    return rc;
  endfunction

endpackage

/* design/noek_key_sched.sv */
module noek_key_sched (
  input  logic              clk,
  input  noek_pkg::blk_t    cfg_key,
  input  logic              cfg_decrypt,
  output noek_pkg::keyctl_t ctl
);
  import noek_pkg::*;

  localparam blk_t NullKey = '0;

  keyctl_t ctl_next;

  always_comb begin
    ctl_next.decrypt = cfg_decrypt;
    ctl_next.key = cfg_decrypt ? theta(NullKey, cfg_key) : cfg_key;
  end

  always_ff @(posedge clk) begin
    ctl <= ctl_next;
  end

  a_enc_key_direct: assert property (@(posedge clk)
    !$past(cfg_decrypt) |-> ctl.key == $past(cfg_key))
    else $error("encrypt working key differs from the configured key");

endmodule

/* design/noek_round_stage.sv */
module noek_round_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  noek_pkg::blk_t in_blk,
  input  noek_pkg::blk_t key,
  input  logic [7:0]     rc1,
  input  logic [7:0]     rc2,
  output logic           out_valid,
  output noek_pkg::blk_t out_blk
);
  import noek_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_blk <= round_fn(key, in_blk, rc1, rc2);
  end

endmodule

/* design/noek_final_stage.sv */
module noek_final_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  noek_pkg::blk_t      in_blk,
  input  noek_pkg::blk_t      key,
  input  logic [7:0]          rc1,
  input  logic [7:0]          rc2,
  output logic                done,
  output noek_pkg::out_word_t result
);
  import noek_pkg::*;

  blk_t res_blk;

  assign res_blk = final_fn(key, in_blk, rc1, rc2);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.result_word0 <= res_blk[0];
    result.result_word1 <= res_blk[1];
    result.result_word2 <= res_blk[2];
    result.result_word3 <= res_blk[3];
  end

endmodule

/* design/noekeon_direct_block_cipher.sv */
// Channel   Handshake           Payload
// input     start, busy         data   (four 32-bit block words)
// output    done                result (four 32-bit block words)
// config    APB psel/penable    key words 0..3 at 0x00..0x0C, mode at 0x10
//
// One word enters per cycle; busy stays low since nothing can stall the pipeline.
// Between taking a word and handing it out lie one input register,
// one register per round and one register after the final theta step.
// Reset clears the stage valid bits and the configuration registers.
// The working key is registered from the configuration registers in the cycle after a write.
module noekeon_direct_block_cipher #(
  parameter int unsigned ROUNDS = noek_pkg::NumRounds
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  noek_pkg::in_word_t                  data,
  output logic                                done,
  output noek_pkg::out_word_t                 result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [noek_pkg::AddrWidth-1:0]      paddr,
  input  logic [noek_pkg::DataWidth-1:0]      pwdata,
  output logic [noek_pkg::DataWidth-1:0]      prdata,
  output logic                                pready
);
  import noek_pkg::*;

  localparam int unsigned Latency = ROUNDS + 2;

  blk_t    key;
  logic    decrypt_mode;
  keyctl_t ctl;
  logic    wr_en;
  logic [2:0] reg_idx;

  logic            in_valid;
  blk_t            in_blk;
  logic [ROUNDS:0] stg_valid;
  blk_t            stg_blk [ROUNDS+1];

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      key          <= '0;
      decrypt_mode <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        RegKey0: key[0] <= pwdata;
        RegKey1: key[1] <= pwdata;
        RegKey2: key[2] <= pwdata;
        RegKey3: key[3] <= pwdata;
        RegMode: decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKey0: prdata = key[0];
      RegKey1: prdata = key[1];
      RegKey2: prdata = key[2];
      RegKey3: prdata = key[3];
      RegMode: prdata = {31'd0, decrypt_mode};
      default: prdata = '0;
    endcase
  end

  noek_key_sched u_key_sched (
    .clk         (clk),
    .cfg_key     (key),
    .cfg_decrypt (decrypt_mode),
    .ctl         (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_blk <= {data.data_word3, data.data_word2, data.data_word1, data.data_word0};
  end

  assign stg_valid[0] = in_valid;
  assign stg_blk[0]   = in_blk;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    logic [7:0] rc1;
    logic [7:0] rc2;
    assign rc1 = ctl.decrypt ? 8'h00 : rc_enc(r);
    assign rc2 = ctl.decrypt ? rc_dec(r) : 8'h00;

    noek_round_stage u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[r]),
      .in_blk    (stg_blk[r]),
      .key       (ctl.key),
      .rc1       (rc1),
      .rc2       (rc2),
      .out_valid (stg_valid[r+1]),
      .out_blk   (stg_blk[r+1])
    );
  end

  logic [7:0] fin_rc1;
  logic [7:0] fin_rc2;
  assign fin_rc1 = ctl.decrypt ? 8'h00 : rc_enc(ROUNDS);
  assign fin_rc2 = ctl.decrypt ? rc_dec(ROUNDS) : 8'h00;

  noek_final_stage u_final (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stg_valid[ROUNDS]),
    .in_blk   (stg_blk[ROUNDS]),
    .key      (ctl.key),
    .rc1      (fin_rc1),
    .rc2      (fin_rc2),
    .done     (done),
    .result   (result)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result word without an accepted input word");

  a_stage_follow: assert property (@(posedge clk) disable iff (rst)
    stg_valid[0] |=> stg_valid[1])
    else $error("pipeline dropped a word after the input register");

  a_cfg_mode: assert property (@(posedge clk) disable iff (rst)
    $past(wr_en && reg_idx == RegMode) |-> decrypt_mode == $past(pwdata[0]))
    else $error("mode register did not take the written value");

endmodule
